[rtl/core/pnlp_pkg.sv]
// ----------------------------------------------------------------------------
// pnlp_pkg
// shared types, codes and character constants of the number literal parser
// ----------------------------------------------------------------------------
`default_nettype none

package pnlp_pkg;

   localparam int CHAR_BITS   = 16;
   localparam int NUMBER_BITS = 32;

   // parse phase codes
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_ZERO   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_ABSORB = 2'd3;

   // radix codes
   localparam logic [1:0] RX_DEC = 2'd0;
   localparam logic [1:0] RX_HEX = 2'd1;
   localparam logic [1:0] RX_BIN = 2'd2;
   localparam logic [1:0] RX_OCT = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_BADDIGIT = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // characters
   localparam logic [CHAR_BITS-1:0] CHAR_NUL     = 16'h0000;
   localparam logic [CHAR_BITS-1:0] CHAR_HASH    = 16'h0023;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 16'h0030;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 16'h0039;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 16'h0041;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_B = 16'h0042;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 16'h0046;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 16'h0058;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 16'h0061;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_B = 16'h0062;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = 16'h0066;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 16'h0078;

   // digit code for a character that is no digit in any base
   localparam logic [4:0] DIGIT_NONE = 5'd16;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] radix_sel;
      logic [1:0] error_code;
   } parse_state_type;

   localparam parse_state_type PARSE_RESTART = '{
      phase:      PH_FIRST,
      radix_sel:  RX_DEC,
      error_code: ST_OK
   };

   function automatic logic [4:0] radix_value(input logic [1:0] sel);
      logic [4:0] base;
      case (sel)
         RX_HEX:  base = 5'd16;
         RX_BIN:  base = 5'd2;
         RX_OCT:  base = 5'd8;
         default: base = 5'd10;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

[rtl/core/pnlp_step.sv]
// ----------------------------------------------------------------------------
// pnlp_step
// folds one character into the parse state; builds the result on terminator
// ----------------------------------------------------------------------------
`default_nettype none

module pnlp_step #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic [pnlp_pkg::CHAR_BITS-1:0]   char_code,
   input  wire pnlp_pkg::parse_state_type        state_cur,
   input  wire logic [VALUE_BITS-1:0]            acc_cur,
   output pnlp_pkg::parse_state_type             state_next,
   output logic [VALUE_BITS-1:0]                 acc_next,
   output logic                                  is_term,
   output logic [1:0]                            status,
   output logic [pnlp_pkg::NUMBER_BITS-1:0]      number
);

   localparam int WIDE_BITS = VALUE_BITS + 4;

   logic [4:0]           digit;
   logic [WIDE_BITS-1:0] acc_wide;
   logic [WIDE_BITS-1:0] product;
   logic [WIDE_BITS-1:0] folded;
   logic                 digit_bad;
   logic                 digit_ovf;

   // digit decode, either case for hex letters
   always_comb begin
      digit = pnlp_pkg::DIGIT_NONE;
      if (char_code inside {[pnlp_pkg::CHAR_ZERO : pnlp_pkg::CHAR_NINE]}) begin
         digit = 5'(char_code - pnlp_pkg::CHAR_ZERO);
      end else if (char_code inside {[pnlp_pkg::CHAR_UPPER_A : pnlp_pkg::CHAR_UPPER_F]}) begin
         digit = 5'(char_code - pnlp_pkg::CHAR_UPPER_A) + 5'd10;
      end else if (char_code inside {[pnlp_pkg::CHAR_LOWER_A : pnlp_pkg::CHAR_LOWER_F]}) begin
         digit = 5'(char_code - pnlp_pkg::CHAR_LOWER_A) + 5'd10;
      end
   end

   // acc * base + digit as shifts and adds; high nibble set means overflow
   always_comb begin
      acc_wide = WIDE_BITS'(acc_cur);
      case (state_cur.radix_sel)
         pnlp_pkg::RX_HEX: product = acc_wide << 4;
         pnlp_pkg::RX_BIN: product = acc_wide << 1;
         pnlp_pkg::RX_OCT: product = acc_wide << 3;
         default:          product = (acc_wide << 3) + (acc_wide << 1);
      endcase
      folded    = product + WIDE_BITS'(digit[3:0]);
      digit_bad = digit >= pnlp_pkg::radix_value(state_cur.radix_sel);
      digit_ovf = |folded[WIDE_BITS-1:VALUE_BITS];
   end

   always_comb begin
      state_next = state_cur;
      acc_next   = acc_cur;
      is_term    = char_code == pnlp_pkg::CHAR_NUL;
      status     = pnlp_pkg::ST_OK;
      number     = '0;
      if (is_term) begin
         case (state_cur.phase)
            pnlp_pkg::PH_FIRST:  status = pnlp_pkg::ST_EMPTY;
            pnlp_pkg::PH_ABSORB: status = state_cur.error_code;
            default:             number = pnlp_pkg::NUMBER_BITS'(acc_cur);
         endcase
         state_next = pnlp_pkg::PARSE_RESTART;
         acc_next   = '0;
      end else begin
         case (state_cur.phase)
            pnlp_pkg::PH_FIRST: begin
               acc_next              = '0;
               state_next.error_code = pnlp_pkg::ST_OK;
               if (char_code == pnlp_pkg::CHAR_HASH) begin
                  state_next.radix_sel = pnlp_pkg::RX_HEX;
                  state_next.phase     = pnlp_pkg::PH_DIGITS;
               end else if (char_code == pnlp_pkg::CHAR_ZERO) begin
                  state_next.radix_sel = pnlp_pkg::RX_OCT;
                  state_next.phase     = pnlp_pkg::PH_ZERO;
               end else begin
                  // first digit is decimal; accumulator is zero here
                  state_next.radix_sel = pnlp_pkg::RX_DEC;
                  if (digit >= pnlp_pkg::radix_value(pnlp_pkg::RX_DEC)) begin
                     state_next.error_code = pnlp_pkg::ST_BADDIGIT;
                     state_next.phase      = pnlp_pkg::PH_ABSORB;
                  end else begin
                     state_next.phase = pnlp_pkg::PH_DIGITS;
                     acc_next         = VALUE_BITS'(digit[3:0]);
                  end
               end
            end
            pnlp_pkg::PH_ZERO, pnlp_pkg::PH_DIGITS: begin
               state_next.phase = pnlp_pkg::PH_DIGITS;
               if (state_cur.phase == pnlp_pkg::PH_ZERO &&
                   (char_code == pnlp_pkg::CHAR_LOWER_X ||
                    char_code == pnlp_pkg::CHAR_UPPER_X)) begin
                  state_next.radix_sel = pnlp_pkg::RX_HEX;
               end else if (state_cur.phase == pnlp_pkg::PH_ZERO &&
                            (char_code == pnlp_pkg::CHAR_LOWER_B ||
                             char_code == pnlp_pkg::CHAR_UPPER_B)) begin
                  state_next.radix_sel = pnlp_pkg::RX_BIN;
               end else if (digit_bad) begin
                  state_next.error_code = pnlp_pkg::ST_BADDIGIT;
                  state_next.phase      = pnlp_pkg::PH_ABSORB;
               end else if (digit_ovf) begin
                  state_next.error_code = pnlp_pkg::ST_OVERFLOW;
                  state_next.phase      = pnlp_pkg::PH_ABSORB;
               end else begin
                  acc_next = folded[VALUE_BITS-1:0];
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/prefixed_number_literal_parser.sv]
// ----------------------------------------------------------------------------
// prefixed_number_literal_parser
// parses a NUL-terminated wide-character string into an unsigned number
// ----------------------------------------------------------------------------
// usage
//  - req channel carries one 16-bit character per request; code 0 ends the
//    string. "0x"/"0X" or "#" selects hex, "0b"/"0B" binary, a leading "0"
//    octal, anything else decimal
//  - rsp channel carries one status/number pair per string, only for the
//    terminator; status 0 ok, 1 empty, 2 invalid digit, 3 overflow
//  - one request per cycle while req_stall is low; each character goes through
//    an input register and the digit fold logic into the parse state, and a
//    terminator's result is registered in the result register, which drives rsp
//  - rsp_stall holds the result register; the input register keeps moving
//    plain characters and only waits when it holds a terminator and the
//    result register is still full, which then stalls req
//  - reset clears both valid flags and returns the parser to the start of
//    a string in decimal with no error
// ----------------------------------------------------------------------------
`default_nettype none

module prefixed_number_literal_parser #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pnlp_pkg::CHAR_BITS-1:0]      req_char_code,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [pnlp_pkg::NUMBER_BITS-1:0]         rsp_number
);

   // input register
   logic                               in_valid_ff, in_valid_in;
   logic [pnlp_pkg::CHAR_BITS-1:0]     in_char_ff;

   // parse state
   pnlp_pkg::parse_state_type          state_ff;
   pnlp_pkg::parse_state_type          state_in;
   logic [VALUE_BITS-1:0]              acc_ff, acc_in;

   // result register
   logic                               out_valid_ff, out_valid_in;
   logic [1:0]                         out_status_ff;
   logic [pnlp_pkg::NUMBER_BITS-1:0]   out_number_ff;

   logic                               step_term;
   logic [1:0]                         step_status;
   logic [pnlp_pkg::NUMBER_BITS-1:0]   step_number;
   logic                               in_advance;
   logic                               in_fire;
   logic                               req_take;

   pnlp_step #(
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .char_code  (in_char_ff),
      .state_cur  (state_ff),
      .acc_cur    (acc_ff),
      .state_next (state_in),
      .acc_next   (acc_in),
      .is_term    (step_term),
      .status     (step_status),
      .number     (step_number)
   );

   // a terminator needs room in the result register; other characters never wait
   assign in_advance = !step_term || !out_valid_ff || !rsp_stall;
   assign in_fire    = in_valid_ff && in_advance;
   assign req_stall  = in_valid_ff && !in_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_fire && step_term) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= pnlp_pkg::PARSE_RESTART;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_fire) begin
            state_ff <= state_in;
            acc_ff   <= acc_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
      end
      if (in_fire && step_term) begin
         out_status_ff <= step_status;
         out_number_ff <= step_number;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_number = out_number_ff;

endmodule

`default_nettype wire
